### rtl/rld_pkg.sv
// Shared constants, types and codes for the run-length decoder.
package rld_pkg;

  // Output lanes per result word (1 to 8).
  localparam int LANES = 8;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CNT_MASK = 8'h7F;
  localparam logic [7:0] RUN_FLAG = 8'h80;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TRUNC_CTRL = 2'd1;
  localparam logic [1:0] ST_TRUNC_LIT  = 2'd2;

  // Front parser phase.
  typedef enum logic [2:0] {
    PH_CTRL = 3'b001,
    PH_RUN  = 3'b010,
    PH_LIT  = 3'b100
  } phase_t;

  // One command for the back end: emit count copies of data, LANES per word.
  // A count of zero gives a single status-only word.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] count;
    logic [1:0] status;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### rtl/rld_front.sv
// Front end: accepts compressed bytes, tracks phase and pushes decode commands.
module rld_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 last,
  output rld_pkg::push_t       push_o
);
  import rld_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] remaining, remaining_next;
  logic [7:0] rem_dec;

  assign rem_dec = (remaining != 8'd0) ? remaining - 8'd1 : 8'd0;

  always_comb begin
    phase_next      = phase;
    remaining_next  = remaining;
    push_o.push     = 1'b0;
    push_o.cmd.data = in_byte;
    push_o.cmd.count  = 8'd1;
    push_o.cmd.status = ST_OK;
    push_o.cmd.done   = last;
    if (accept) begin
      case (phase)
        PH_RUN: begin
          push_o.push      = 1'b1;
          push_o.cmd.count = remaining;
          phase_next       = PH_CTRL;
          remaining_next   = 8'd0;
        end
        PH_LIT: begin
          push_o.push = 1'b1;
          if (rem_dec == 8'd0) begin
            phase_next     = PH_CTRL;
            remaining_next = 8'd0;
          end else if (last) begin
            // block cut short by end of stream
            push_o.cmd.status = ST_TRUNC_LIT;
            phase_next        = PH_CTRL;
            remaining_next    = 8'd0;
          end else begin
            remaining_next = rem_dec;
          end
        end
        default: begin
          if (last) begin
            push_o.push       = 1'b1;
            push_o.cmd.data   = 8'd0;
            push_o.cmd.count  = 8'd0;
            push_o.cmd.status = ST_TRUNC_CTRL;
            phase_next        = PH_CTRL;
            remaining_next    = 8'd0;
          end else begin
            remaining_next = (in_byte & CNT_MASK) + 8'd1;
            phase_next     = ((in_byte & RUN_FLAG) != 8'd0) ? PH_RUN : PH_LIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CTRL;
      remaining <= 8'd0;
    end else begin
      phase     <= phase_next;
      remaining <= remaining_next;
    end
  end

endmodule

### rtl/rld_queue.sv
// Command queue between the front and back ends.
module rld_queue (
  input  logic             clk,
  input  logic             rst,
  input  rld_pkg::push_t   push_i,
  input  logic             pop,
  output rld_pkg::cmd_t    head,
  output rld_pkg::qstat_t  stat
);
  import rld_pkg::*;

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QCW-1:0] fill;
  logic           do_push, do_pop;

  assign stat.full  = (fill == QCW'(QDEPTH));
  assign stat.empty = (fill == '0);
  assign do_push    = push_i.push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rptr];

  function automatic logic [QAW-1:0] wrap_inc(input logic [QAW-1:0] p);
    return (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wptr <= wrap_inc(wptr);
      if (do_pop)  rptr <= wrap_inc(rptr);
      case ({do_push, do_pop})
        2'b10:   fill <= fill + QCW'(1);
        2'b01:   fill <= fill - QCW'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= push_i.cmd;
  end

endmodule

### rtl/rld_back.sv
// Back end: expands queued commands into output words through an output register.
module rld_back (
  input  logic             clk,
  input  logic             rst,
  input  rld_pkg::cmd_t    head,
  input  rld_pkg::qstat_t  stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      out_data,
  output logic [3:0]       byte_count,
  output logic             end_mark,
  output logic [1:0]       status,
  output logic             stream_done
);
  import rld_pkg::*;

  logic       cur_valid;
  cmd_t       cur;
  logic [7:0] left;
  logic       out_free, final_word, emit;
  logic [3:0] take;
  logic [63:0] word;

  assign out_free   = !out_valid || !out_stall;
  assign final_word = (left <= 8'(LANES));
  assign take       = final_word ? left[3:0] : 4'(LANES);
  assign emit       = cur_valid && out_free;
  assign pop        = !stat.empty && (!cur_valid || (emit && final_word));

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word[8*i +: 8] = (4'(i) < take) ? cur.data : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (emit && final_word) begin
        cur_valid <= 1'b0;
      end
      if (out_free) out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= head;
      left <= head.count;
    end else if (emit) begin
      left <= left - 8'(take);
    end
    if (emit) begin
      out_data    <= word;
      byte_count  <= take;
      end_mark    <= final_word;
      status      <= final_word ? cur.status : ST_OK;
      stream_done <= final_word && cur.done;
    end
  end

endmodule

### rtl/run_length_decoder.sv
// Top level of the PackBits-style run-length decoder.
//
// Input channel: in_byte and last, accepted when in_valid is high and in_stall
// is low. Output channel: out_data, byte_count, end_mark, status, stream_done,
// taken when out_valid is high and out_stall is low.
// A control byte is absorbed by the front end and gives no word,
// except when it carries last: then one status-only word is sent.
// Each literal byte gives one word; a run value gives ceil(count / LANES)
// words, one per cycle while the receiver takes them.
// The front end takes one byte per cycle until the four-entry command queue
// fills; the back end then sets the rate, one output word per unstalled cycle.
// An accepted byte reaches its first output word through the command queue,
// the back end's current command register and then the output register.
// If the receiver stalls, the output register holds its word, the back end
// holds, the queue fills and in_stall rises.
// Synchronous reset empties the queue and the output register and returns
// the parser to expecting a control byte.
module run_length_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data,
  output logic [3:0]  byte_count,
  output logic        end_mark,
  output logic [1:0]  status,
  output logic        stream_done
);
  import rld_pkg::*;

  push_t  push_w;
  cmd_t   head_w;
  qstat_t stat_w;
  logic   pop_w;
  logic   accept;

  assign in_stall = stat_w.full;
  assign accept   = in_valid && !in_stall;

  rld_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .last    (last),
    .push_o  (push_w)
  );

  rld_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push_i (push_w),
    .pop    (pop_w),
    .head   (head_w),
    .stat   (stat_w)
  );

  rld_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_w),
    .stat        (stat_w),
    .pop         (pop_w),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .byte_count  (byte_count),
    .end_mark    (end_mark),
    .status      (status),
    .stream_done (stream_done)
  );

`ifndef SYNTHESIS
  a_no_push_lost: assert property (@(posedge clk) disable iff (rst)
    push_w.push |-> !stat_w.full)
    else $error("command pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count <= 4'(LANES)))
    else $error("byte_count above lane count");

  a_done_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (stream_done || status != ST_OK)) |-> end_mark)
    else $error("stream end or error flagged on a non-final word");

  a_empty_is_trunc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_count == 4'd0) |-> (status == ST_TRUNC_CTRL && stream_done))
    else $error("status-only word without truncation flag");
`endif

endmodule
